// ===== hdl/nearest_ray_triangle_hit_defines.svh =====
// ----------------------------------------------------------------------------
// nearest ray triangle hit assertion macros
// concurrent assertion wrappers used by the back sequencer
// ----------------------------------------------------------------------------
`ifndef NEAREST_RAY_TRIANGLE_HIT_DEFINES_SVH
`define NEAREST_RAY_TRIANGLE_HIT_DEFINES_SVH
`ifndef NO_ASSERTIONS
`define NRTH_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);
`define NRTH_ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define NRTH_ASSERT(lbl, prop, msg)
`define NRTH_ASSERT_ALWAYS(lbl, prop, msg)
`endif
`endif

// ===== hdl/nrth_pkg.sv =====
// ----------------------------------------------------------------------------
// nearest ray triangle hit package
// widths, constants, register indexes and the multiply-accumulate program
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
package nrth_pkg;

	localparam int CW     = 32;
	localparam int EW     = 33;
	localparam int VW     = 66;
	localparam int ACC_W  = 102;
	localparam int QW     = 63;
	localparam int QF     = 61;
	localparam int FRAC   = 40;
	localparam int SAT_SH = QF - FRAC;
	localparam int NSW    = 60;
	localparam int NW     = 64;
	localparam int DW     = 31;
	localparam int T24W   = QW - 16;
	localparam int STEP_W = 6;
	localparam int FIFO_DEPTH = 2;

	localparam logic [STEP_W-1:0] ITER_LAST = 6'd32;
	localparam logic [STEP_W-1:0] LAST_STEP = 6'd35;
	localparam logic [STEP_W-1:0] DIV_LAST  = 6'd60;

	localparam logic signed [QW-1:0] EPS_Q    = 63'sd1100;
	localparam logic signed [QW-1:0] EPS_NEG  = -63'sd1100;
	localparam logic signed [QW-1:0] ONE_PLUS = 63'sd1099511628876;
	localparam logic [ACC_W-1:0]     DET_MIN  = 102'd4722367;
	localparam logic [63:0]          DIR_MIN  = 64'd282;
	localparam logic [NSW-1:0]       NRM_DEGEN = 60'd79228162514264337;
	localparam logic [VW-1:0]        SMALL_LIM = 66'd536870912;
	localparam logic signed [VW-1:0] PLUS_Z   = 66'sh1000000000000;
	localparam logic [CW-1:0]        UNLIMITED = 32'h8000_0000;
	localparam logic signed [CW-1:0] DIR_Z_RST = 32'sh0100_0000;

	typedef enum logic [2:0] {
		REG_ORIGIN_X, REG_ORIGIN_Y, REG_ORIGIN_Z,
		REG_DIR_X, REG_DIR_Y, REG_DIR_Z, REG_MAX_DISTANCE
	} cfg_reg_t;

	typedef enum logic [2:0] {A_D, A_E1, A_E2, A_TV, A_NV} asrc_t;
	typedef enum logic [2:0] {B_D, B_E1, B_E2, B_PV, B_QV, B_NV} bsrc_t;
	typedef enum logic [3:0] {
		W_NONE, W_SQ, W_PV, W_DET, W_QV, W_NU, W_NVN, W_NT, W_NV, W_NS
	} dst_t;

	typedef struct packed {
		asrc_t       asrc;
		logic [1:0]  ai;
		bsrc_t       bsrc;
		logic [1:0]  bi;
		logic        clr;
		logic        neg;
		dst_t        dst;
		logic [1:0]  di;
	} mac_op_t;

	function automatic mac_op_t mk(asrc_t as, logic [1:0] ai, bsrc_t bs, logic [1:0] bi,
			logic clr, logic neg, dst_t dst, logic [1:0] di);
		mac_op_t o;
		o.asrc = as; o.ai = ai; o.bsrc = bs; o.bi = bi;
		o.clr = clr; o.neg = neg; o.dst = dst; o.di = di;
		return o;
	endfunction

	function automatic mac_op_t mac_prog(logic [STEP_W-1:0] step);
		mac_op_t o;
		unique case (step)
			6'd0:  o = mk(A_D,  2'd0, B_D,  2'd0, 1'b1, 1'b0, W_NONE, 2'd0);
			6'd1:  o = mk(A_D,  2'd1, B_D,  2'd1, 1'b0, 1'b0, W_NONE, 2'd0);
			6'd2:  o = mk(A_D,  2'd2, B_D,  2'd2, 1'b0, 1'b0, W_SQ,   2'd0);
			6'd3:  o = mk(A_D,  2'd1, B_E2, 2'd2, 1'b1, 1'b0, W_NONE, 2'd0);
			6'd4:  o = mk(A_D,  2'd2, B_E2, 2'd1, 1'b0, 1'b1, W_PV,   2'd0);
			6'd5:  o = mk(A_D,  2'd2, B_E2, 2'd0, 1'b1, 1'b0, W_NONE, 2'd0);
			6'd6:  o = mk(A_D,  2'd0, B_E2, 2'd2, 1'b0, 1'b1, W_PV,   2'd1);
			6'd7:  o = mk(A_D,  2'd0, B_E2, 2'd1, 1'b1, 1'b0, W_NONE, 2'd0);
			6'd8:  o = mk(A_D,  2'd1, B_E2, 2'd0, 1'b0, 1'b1, W_PV,   2'd2);
			6'd9:  o = mk(A_E1, 2'd0, B_PV, 2'd0, 1'b1, 1'b0, W_NONE, 2'd0);
			6'd10: o = mk(A_E1, 2'd1, B_PV, 2'd1, 1'b0, 1'b0, W_NONE, 2'd0);
			6'd11: o = mk(A_E1, 2'd2, B_PV, 2'd2, 1'b0, 1'b0, W_DET,  2'd0);
			6'd12: o = mk(A_TV, 2'd1, B_E1, 2'd2, 1'b1, 1'b0, W_NONE, 2'd0);
			6'd13: o = mk(A_TV, 2'd2, B_E1, 2'd1, 1'b0, 1'b1, W_QV,   2'd0);
			6'd14: o = mk(A_TV, 2'd2, B_E1, 2'd0, 1'b1, 1'b0, W_NONE, 2'd0);
			6'd15: o = mk(A_TV, 2'd0, B_E1, 2'd2, 1'b0, 1'b1, W_QV,   2'd1);
			6'd16: o = mk(A_TV, 2'd0, B_E1, 2'd1, 1'b1, 1'b0, W_NONE, 2'd0);
			6'd17: o = mk(A_TV, 2'd1, B_E1, 2'd0, 1'b0, 1'b1, W_QV,   2'd2);
			6'd18: o = mk(A_TV, 2'd0, B_PV, 2'd0, 1'b1, 1'b0, W_NONE, 2'd0);
			6'd19: o = mk(A_TV, 2'd1, B_PV, 2'd1, 1'b0, 1'b0, W_NONE, 2'd0);
			6'd20: o = mk(A_TV, 2'd2, B_PV, 2'd2, 1'b0, 1'b0, W_NU,   2'd0);
			6'd21: o = mk(A_D,  2'd0, B_QV, 2'd0, 1'b1, 1'b0, W_NONE, 2'd0);
			6'd22: o = mk(A_D,  2'd1, B_QV, 2'd1, 1'b0, 1'b0, W_NONE, 2'd0);
			6'd23: o = mk(A_D,  2'd2, B_QV, 2'd2, 1'b0, 1'b0, W_NVN,  2'd0);
			6'd24: o = mk(A_E2, 2'd0, B_QV, 2'd0, 1'b1, 1'b0, W_NONE, 2'd0);
			6'd25: o = mk(A_E2, 2'd1, B_QV, 2'd1, 1'b0, 1'b0, W_NONE, 2'd0);
			6'd26: o = mk(A_E2, 2'd2, B_QV, 2'd2, 1'b0, 1'b0, W_NT,   2'd0);
			6'd27: o = mk(A_E1, 2'd1, B_E2, 2'd2, 1'b1, 1'b0, W_NONE, 2'd0);
			6'd28: o = mk(A_E1, 2'd2, B_E2, 2'd1, 1'b0, 1'b1, W_NV,   2'd0);
			6'd29: o = mk(A_E1, 2'd2, B_E2, 2'd0, 1'b1, 1'b0, W_NONE, 2'd0);
			6'd30: o = mk(A_E1, 2'd0, B_E2, 2'd2, 1'b0, 1'b1, W_NV,   2'd1);
			6'd31: o = mk(A_E1, 2'd0, B_E2, 2'd1, 1'b1, 1'b0, W_NONE, 2'd0);
			6'd32: o = mk(A_E1, 2'd1, B_E2, 2'd0, 1'b0, 1'b1, W_NV,   2'd2);
			6'd33: o = mk(A_NV, 2'd0, B_NV, 2'd0, 1'b1, 1'b0, W_NONE, 2'd0);
			6'd34: o = mk(A_NV, 2'd1, B_NV, 2'd1, 1'b0, 1'b0, W_NONE, 2'd0);
			6'd35: o = mk(A_NV, 2'd2, B_NV, 2'd2, 1'b0, 1'b0, W_NS,   2'd0);
			default: o = mk(A_D, 2'd0, B_D, 2'd0, 1'b1, 1'b0, W_NONE, 2'd0);
		endcase
		return o;
	endfunction

endpackage

// ===== hdl/nrth_fifo.sv =====
// ----------------------------------------------------------------------------
// nrth fifo
// short queue between the front stage and the back sequencer
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module nrth_fifo import nrth_pkg::*; #(
	parameter int WIDTH = 322
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] din,
	output logic             full,
	input  logic             pop,
	output logic             empty,
	output logic [WIDTH-1:0] dout
);
	localparam int PW = $clog2(FIFO_DEPTH);

	logic [WIDTH-1:0] mem_q [FIFO_DEPTH];
	logic [PW-1:0]    wr_ptr_q;
	logic [PW-1:0]    rd_ptr_q;
	logic [PW:0]      cnt_q;

	assign full  = (cnt_q == (PW+1)'(FIFO_DEPTH));
	assign empty = (cnt_q == '0);
	assign dout  = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push)
				wr_ptr_q <= wr_ptr_q + 1'b1;
			if (pop)
				rd_ptr_q <= rd_ptr_q + 1'b1;
			if (push && !pop)
				cnt_q <= cnt_q + 1'b1;
			else if (pop && !push)
				cnt_q <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (push)
			mem_q[wr_ptr_q] <= din;
	end
endmodule

// ===== hdl/nrth_front.sv =====
// ----------------------------------------------------------------------------
// nrth front
// accepts triangle words and forms the edge and origin offset vectors
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module nrth_front import nrth_pkg::*; #(
	parameter int TRI_ID_BITS = 24
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         s_tvalid,
	output logic                         s_tready,
	input  logic [8*((9*CW+TRI_ID_BITS+7)/8)-1:0] s_tdata,
	input  logic                         s_tlast,
	input  logic signed [CW-1:0]         origin [3],
	output logic                         push,
	input  logic                         full,
	output logic [9*EW+TRI_ID_BITS:0]    item
);
	logic                       v_s1;
	logic [9*EW+TRI_ID_BITS:0]  item_s1;
	logic [9*EW+TRI_ID_BITS:0]  item_nx;
	logic signed [EW-1:0]       av, bv, cv, ov;

	assign s_tready = !v_s1 || !full;
	assign push     = v_s1 && !full;
	assign item     = item_s1;

	always_comb begin
		item_nx = '0;
		for (int j = 0; j < 3; j++) begin
			av = EW'($signed(s_tdata[j*CW +: CW]));
			bv = EW'($signed(s_tdata[(3+j)*CW +: CW]));
			cv = EW'($signed(s_tdata[(6+j)*CW +: CW]));
			ov = EW'(origin[j]);
			item_nx[j*EW +: EW]     = bv - av;
			item_nx[(3+j)*EW +: EW] = cv - av;
			item_nx[(6+j)*EW +: EW] = ov - av;
		end
		item_nx[9*EW +: TRI_ID_BITS] = s_tdata[9*CW +: TRI_ID_BITS];
		item_nx[9*EW+TRI_ID_BITS]    = s_tlast;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else begin
			if (s_tvalid && s_tready)
				v_s1 <= 1'b1;
			else if (push)
				v_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready)
			item_s1 <= item_nx;
	end
endmodule

// ===== hdl/nrth_div.sv =====
// ----------------------------------------------------------------------------
// nrth div
// radix-2 restoring divider giving saturated signed q.40 quotients
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module nrth_div import nrth_pkg::*; (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    start,
	input  logic signed [ACC_W-1:0] num,
	input  logic [ACC_W-1:0]        den,
	output logic                    busy,
	output logic                    done,
	output logic signed [QW-1:0]    quo
);
	localparam int RW = ACC_W + 1;
	localparam logic [QW-1:0] QSAT = QW'(1) << QF;

	typedef enum logic [1:0] {D_IDLE, D_SAT, D_RUN, D_DONE} dstate_t;

	dstate_t          state_q;
	logic [STEP_W-1:0] k_q;
	logic [ACC_W-1:0] mag_q;
	logic [ACC_W-1:0] den_q;
	logic             neg_q;
	logic             sat_q;
	logic [RW-1:0]    r_q;
	logic [QF-1:0]    dsh_q;
	logic [QF-1:0]    q_q;
	logic [RW-1:0]    r2;
	logic             ge;
	logic [QW-1:0]    qmag;

	assign busy = (state_q != D_IDLE);
	assign done = (state_q == D_DONE);
	assign r2   = {r_q[RW-2:0], dsh_q[QF-1]};
	assign ge   = (r2 >= {1'b0, den_q});
	assign qmag = sat_q ? QSAT : QW'(q_q);
	assign quo  = neg_q ? -$signed(qmag) : $signed(qmag);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= D_IDLE;
			k_q     <= '0;
		end else begin
			unique case (state_q)
				D_IDLE: if (start) state_q <= D_SAT;
				D_SAT: begin
					k_q     <= '0;
					state_q <= D_RUN;
				end
				D_RUN: begin
					k_q <= k_q + 1'b1;
					if (k_q == DIV_LAST)
						state_q <= D_DONE;
				end
				D_DONE: state_q <= D_IDLE;
				default: state_q <= D_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == D_IDLE && start) begin
			mag_q <= num[ACC_W-1] ? ACC_W'(-num) : ACC_W'(num);
			neg_q <= num[ACC_W-1];
			den_q <= den;
		end
		if (state_q == D_SAT) begin
			sat_q <= ({{SAT_SH{1'b0}}, mag_q} >= {den_q, {SAT_SH{1'b0}}});
			r_q   <= RW'(mag_q >> SAT_SH);
			dsh_q <= {mag_q[SAT_SH-1:0], {FRAC{1'b0}}};
			q_q   <= '0;
		end
		if (state_q == D_RUN) begin
			r_q   <= ge ? r2 - {1'b0, den_q} : r2;
			q_q   <= {q_q[QF-2:0], ge};
			dsh_q <= {dsh_q[QF-2:0], 1'b0};
		end
	end
endmodule

// ===== hdl/nrth_back.sv =====
// ----------------------------------------------------------------------------
// nrth back
// bit-serial multiply-accumulate sequencer, hit test and nearest-hit keeper
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "nearest_ray_triangle_hit_defines.svh"
module nrth_back import nrth_pkg::*; #(
	parameter int TRI_ID_BITS = 24
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          q_empty,
	input  logic [9*EW+TRI_ID_BITS:0]     q_data,
	output logic                          q_pop,
	input  logic signed [CW-1:0]          dir [3],
	input  logic [DW-1:0]                 max_distance,
	output logic                          res_valid,
	input  logic                          res_ready,
	output logic [8*((1+DW+TRI_ID_BITS+3*NW+7)/8)-1:0] res_data
);
	localparam int OUT_W = 8*((1+DW+TRI_ID_BITS+3*NW+7)/8);

	typedef enum logic [2:0] {
		S_IDLE, S_LOAD, S_RUN, S_WB, S_DIV, S_DIVW, S_DECIDE, S_EMIT
	} state_t;
	typedef enum logic [1:0] {QS_U, QS_V, QS_T} qsel_t;

	state_t              state_q;
	qsel_t               qsel_q;
	logic [STEP_W-1:0]   step_q;
	logic [STEP_W-1:0]   cnt_q;
	logic                have_q;
	logic [DW-1:0]       best_dist_q;
	logic [TRI_ID_BITS-1:0] best_id_q;
	logic [NW-1:0]       best_nrm_q [3];
	logic                res_valid_q;
	logic [OUT_W-1:0]    res_data_q;

	logic signed [EW-1:0]    e1_q [3];
	logic signed [EW-1:0]    e2_q [3];
	logic signed [EW-1:0]    tv_q [3];
	logic [TRI_ID_BITS-1:0]  id_q;
	logic                    last_q;
	mac_op_t                 op_q;
	mac_op_t                 op_cur;
	logic [EW-1:0]           asr_q;
	logic signed [ACC_W-1:0] bsh_q;
	logic signed [ACC_W-1:0] acc_q;
	logic [63:0]             sq_q;
	logic signed [VW-1:0]    pv_q [3];
	logic signed [VW-1:0]    qv_q [3];
	logic signed [VW-1:0]    nv_q [3];
	logic signed [ACC_W-1:0] det_q, nu_q, nvn_q, nt_q;
	logic [NSW-1:0]          ns_q;
	logic signed [QW-1:0]    u_q, v_q, t_q;

	logic signed [EW-1:0]    a_sel;
	logic signed [ACC_W-1:0] b_sel;
	logic                    sub;
	logic [ACC_W-1:0]        det_abs;
	logic signed [ACC_W-1:0] num_sel, num_adj;
	logic                    div_start, div_busy, div_done;
	logic signed [QW-1:0]    div_quo;

	logic                    accept, nv_tiny, degen, flip;
	logic signed [QW:0]      uv_sum;
	logic [T24W-1:0]         t24;
	logic [CW-1:0]           limit;
	logic [VW-1:0]           lane_mag [3];
	logic signed [VW-1:0]    nvec [3];
	logic signed [VW-1:0]    nf [3];
	logic                    emit_load;

	assign op_cur    = mac_prog(step_q);
	assign q_pop     = (state_q == S_IDLE) && !q_empty;
	assign res_valid = res_valid_q;
	assign res_data  = res_data_q;
	assign sub       = op_q.neg ^ (cnt_q == ITER_LAST);
	assign det_abs   = det_q[ACC_W-1] ? ACC_W'(-det_q) : ACC_W'(det_q);
	assign div_start = (state_q == S_DIV);
	assign emit_load = (state_q == S_EMIT) && (!res_valid_q || res_ready);

	always_comb begin
		a_sel = '0;
		unique case (op_cur.asrc)
			A_D:  a_sel = EW'(dir[op_cur.ai]);
			A_E1: a_sel = e1_q[op_cur.ai];
			A_E2: a_sel = e2_q[op_cur.ai];
			A_TV: a_sel = tv_q[op_cur.ai];
			A_NV: a_sel = nv_q[op_cur.ai][EW-1:0];
			default: a_sel = '0;
		endcase
		b_sel = '0;
		unique case (op_cur.bsrc)
			B_D:  b_sel = ACC_W'(dir[op_cur.bi]);
			B_E1: b_sel = ACC_W'(e1_q[op_cur.bi]);
			B_E2: b_sel = ACC_W'(e2_q[op_cur.bi]);
			B_PV: b_sel = ACC_W'(pv_q[op_cur.bi]);
			B_QV: b_sel = ACC_W'(qv_q[op_cur.bi]);
			B_NV: b_sel = ACC_W'(nv_q[op_cur.bi]);
			default: b_sel = '0;
		endcase
	end

	always_comb begin
		unique case (qsel_q)
			QS_U: num_sel = nu_q;
			QS_V: num_sel = nvn_q;
			QS_T: num_sel = nt_q;
			default: num_sel = nt_q;
		endcase
		num_adj = det_q[ACC_W-1] ? -num_sel : num_sel;
	end

	nrth_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (num_adj),
		.den    (det_abs),
		.busy   (div_busy),
		.done   (div_done),
		.quo    (div_quo)
	);

	always_comb begin
		uv_sum  = (QW+1)'(u_q) + (QW+1)'(v_q);
		t24     = t_q[QW-1:16];
		limit   = (max_distance != '0) ? CW'(max_distance) : UNLIMITED;
		nv_tiny = 1'b1;
		for (int i = 0; i < 3; i++) begin
			lane_mag[i] = nv_q[i][VW-1] ? VW'(-nv_q[i]) : VW'(nv_q[i]);
			if (lane_mag[i] >= SMALL_LIM)
				nv_tiny = 1'b0;
		end
		degen = nv_tiny && (ns_q <= NRM_DEGEN);
		flip  = degen ? (dir[2] > 0) : det_q[ACC_W-1];
		for (int i = 0; i < 3; i++) begin
			nvec[i] = degen ? ((i == 2) ? PLUS_Z : '0) : nv_q[i];
			nf[i]   = flip ? -nvec[i] : nvec[i];
		end
		accept = (sq_q >= DIR_MIN) && (det_abs >= DET_MIN)
			&& (u_q >= EPS_NEG) && (u_q <= ONE_PLUS)
			&& (v_q >= EPS_NEG) && (uv_sum <= ONE_PLUS)
			&& (t_q > EPS_Q) && (t24 < T24W'(limit))
			&& (!have_q || (t24 < T24W'(best_dist_q)));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			qsel_q      <= QS_U;
			step_q      <= '0;
			cnt_q       <= '0;
			have_q      <= 1'b0;
			best_dist_q <= '0;
			best_id_q   <= '0;
			best_nrm_q  <= '{default: '0};
			res_valid_q <= 1'b0;
		end else begin
			if (emit_load)
				res_valid_q <= 1'b1;
			else if (res_ready)
				res_valid_q <= 1'b0;
			unique case (state_q)
				S_IDLE: if (!q_empty) begin
					step_q  <= '0;
					state_q <= S_LOAD;
				end
				S_LOAD: begin
					cnt_q   <= '0;
					state_q <= S_RUN;
				end
				S_RUN: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == ITER_LAST)
						state_q <= S_WB;
				end
				S_WB: begin
					if (step_q == LAST_STEP) begin
						qsel_q  <= QS_U;
						state_q <= S_DIV;
					end else begin
						step_q  <= step_q + 1'b1;
						state_q <= S_LOAD;
					end
				end
				S_DIV: state_q <= S_DIVW;
				S_DIVW: if (div_done) begin
					unique case (qsel_q)
						QS_U: begin
							qsel_q  <= QS_V;
							state_q <= S_DIV;
						end
						QS_V: begin
							qsel_q  <= QS_T;
							state_q <= S_DIV;
						end
						default: state_q <= S_DECIDE;
					endcase
				end
				S_DECIDE: begin
					if (accept) begin
						have_q      <= 1'b1;
						best_dist_q <= t24[DW-1:0];
						best_id_q   <= id_q;
						for (int i = 0; i < 3; i++)
							best_nrm_q[i] <= nf[i][VW-1:2];
					end
					state_q <= last_q ? S_EMIT : S_IDLE;
				end
				S_EMIT: if (emit_load) begin
					have_q      <= 1'b0;
					best_dist_q <= '0;
					best_id_q   <= '0;
					best_nrm_q  <= '{default: '0};
					state_q     <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			for (int j = 0; j < 3; j++) begin
				e1_q[j] <= q_data[j*EW +: EW];
				e2_q[j] <= q_data[(3+j)*EW +: EW];
				tv_q[j] <= q_data[(6+j)*EW +: EW];
			end
			id_q   <= q_data[9*EW +: TRI_ID_BITS];
			last_q <= q_data[9*EW+TRI_ID_BITS];
		end
		if (state_q == S_LOAD) begin
			op_q  <= op_cur;
			asr_q <= a_sel;
			bsh_q <= b_sel;
			if (op_cur.clr)
				acc_q <= '0;
		end
		if (state_q == S_RUN) begin
			if (asr_q[0])
				acc_q <= acc_q + (sub ? -bsh_q : bsh_q);
			asr_q <= asr_q >> 1;
			bsh_q <= bsh_q <<< 1;
		end
		if (state_q == S_WB) begin
			unique case (op_q.dst)
				W_NONE: ;
				W_SQ:   sq_q <= acc_q[63:0];
				W_PV:   pv_q[op_q.di] <= acc_q[VW-1:0];
				W_DET:  det_q <= acc_q;
				W_QV:   qv_q[op_q.di] <= acc_q[VW-1:0];
				W_NU:   nu_q <= acc_q;
				W_NVN:  nvn_q <= acc_q;
				W_NT:   nt_q <= acc_q;
				W_NV:   nv_q[op_q.di] <= acc_q[VW-1:0];
				W_NS:   ns_q <= acc_q[NSW-1:0];
				default: ;
			endcase
		end
		if (state_q == S_DIVW && div_done) begin
			unique case (qsel_q)
				QS_U: u_q <= div_quo;
				QS_V: v_q <= div_quo;
				QS_T: t_q <= div_quo;
				default: t_q <= div_quo;
			endcase
		end
		if (emit_load)
			res_data_q <= OUT_W'({best_nrm_q[2], best_nrm_q[1], best_nrm_q[0],
				best_id_q, best_dist_q, have_q});
	end

	`NRTH_ASSERT(a_pop_nonempty, q_pop |-> !q_empty, "queue popped while empty")
	`NRTH_ASSERT(a_div_idle, div_start |-> !div_busy, "divider started while busy")
	`NRTH_ASSERT(a_clear_best, !have_q |-> (best_dist_q == '0 && best_id_q == '0), "stale best hit")
	`NRTH_ASSERT_ALWAYS(a_mac_count, (state_q == S_RUN) |-> (cnt_q <= ITER_LAST), "mac count overrun")
endmodule

// ===== hdl/nearest_ray_triangle_hit.sv =====
// ----------------------------------------------------------------------------
// nearest ray triangle hit
// streams candidate triangles against one ray and reports the nearest hit
// ----------------------------------------------------------------------------
// the ray (origin, direction, distance limit) is set through the cfg write
// port; the user must write it only while the block is idle, as the block
// does not enforce this. triangles arrive as words on the s_ channel, s_tlast
// marking the final candidate of a ray. one result word leaves on the m_
// channel after each last triangle: hit flag, distance, id and the face
// normal turned toward the ray. a front stage forms the edge vectors and
// hands them through a two-entry queue to the back sequencer. the back runs
// 36 signed products through one bit-serial multiply-accumulate unit and
// three quotients through a radix-2 divider, and pops the next triangle only
// once it is done with the last. reset clears the ray registers (direction
// +z, no limit) and the best hit. a stalled receiver holds the result word;
// the back keeps testing triangles and waits only when the next result word
// is due.
`timescale 1ns / 1ps
module nearest_ray_triangle_hit import nrth_pkg::*; #(
	parameter int TRI_ID_BITS = 24
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [2:0]  cfg_index,
	input  logic [CW-1:0] cfg_data,
	input  logic        s_tvalid,
	output logic        s_tready,
	// a_x, a_y, a_z, b_x, b_y, b_z, c_x, c_y, c_z, triangle_id
	input  logic [8*((9*CW+TRI_ID_BITS+7)/8)-1:0] s_tdata,
	input  logic        s_tlast,
	output logic        m_tvalid,
	input  logic        m_tready,
	// hit_found, hit_distance, hit_triangle, normal_x, normal_y, normal_z
	output logic [8*((1+DW+TRI_ID_BITS+3*NW+7)/8)-1:0] m_tdata
);
	localparam int ITEM_W = 9*EW + TRI_ID_BITS + 1;

	logic signed [CW-1:0] origin_q [3];
	logic signed [CW-1:0] dir_q [3];
	logic [DW-1:0]        max_distance_q;
	logic                 push, full, pop, empty;
	logic [ITEM_W-1:0]    item, q_data;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			origin_q       <= '{default: '0};
			dir_q          <= '{'0, '0, DIR_Z_RST};
			max_distance_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_ORIGIN_X:     origin_q[0] <= cfg_data;
				REG_ORIGIN_Y:     origin_q[1] <= cfg_data;
				REG_ORIGIN_Z:     origin_q[2] <= cfg_data;
				REG_DIR_X:        dir_q[0] <= cfg_data;
				REG_DIR_Y:        dir_q[1] <= cfg_data;
				REG_DIR_Z:        dir_q[2] <= cfg_data;
				REG_MAX_DISTANCE: max_distance_q <= cfg_data[DW-1:0];
				default: ;
			endcase
		end
	end

	nrth_front #(.TRI_ID_BITS(TRI_ID_BITS)) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.origin   (origin_q),
		.push     (push),
		.full     (full),
		.item     (item)
	);

	nrth_fifo #(.WIDTH(ITEM_W)) u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.din    (item),
		.full   (full),
		.pop    (pop),
		.empty  (empty),
		.dout   (q_data)
	);

	nrth_back #(.TRI_ID_BITS(TRI_ID_BITS)) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.q_empty      (empty),
		.q_data       (q_data),
		.q_pop        (pop),
		.dir          (dir_q),
		.max_distance (max_distance_q),
		.res_valid    (m_tvalid),
		.res_ready    (m_tready),
		.res_data     (m_tdata)
	);
endmodule
